FILE: rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg: shared types and constants of the sliding window rate meter
// Field widths, ring geometry, opcodes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package swrm_pkg;

  // Ring geometry. The ring holds a power-of-two number of bins.
  localparam int BIN_IDX_W = 4;
  localparam int NUM_BINS  = 1 << BIN_IDX_W;
  localparam int CNT_W     = BIN_IDX_W + 1;

  // Field widths.
  localparam int TS_W     = 48;
  localparam int BYTES_W  = 32;
  localparam int RATE_W   = 47;
  localparam int BIN_MS_W = 16;
  localparam int OP_W     = 2;

  // Bus widths, fields packed from bit 0 and padded to whole bytes.
  localparam int IN_DATA_W  = ((TS_W + BYTES_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((RATE_W + 7) / 8) * 8;

  localparam logic [BIN_MS_W-1:0] BIN_MS_RESET = BIN_MS_W'(1000);

  // Milliseconds per second and the bits that it needs.
  localparam int MS_PER_SEC   = 1000;
  localparam int MS_PER_SEC_W = 10;

  // Window total and its scaled value.
  localparam int SUM_W  = BYTES_W + BIN_IDX_W;
  localparam int PROD_W = SUM_W + MS_PER_SEC_W;

  // Shared divider: dividend holds a timestamp or the scaled total,
  // divisor holds bin_ms or bin_ms times the window bin count.
  localparam int DIV_NUM_W = TS_W;
  localparam int DIV_DEN_W = BIN_MS_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [TS_W-1:0] SLOT_MAX = {{(TS_W-1){1'b1}}, 1'b0};

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT_DIV,
    ST_ADVANCE,
    ST_CLAMP,
    ST_APPLY,
    ST_SUM,
    ST_SCALE,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic slot_div_start;
    logic take_slot;
    logic advance;
    logic clamp;
    logic apply_add;
    logic apply_clear;
    logic sum_init;
    logic sum_step;
    logic scale;
    logic rate_div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_done;
    logic            sum_last;
  } stat_t;

endpackage

FILE: rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Operands are latched at
// start; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module swrm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [swrm_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [swrm_pkg::DIV_DEN_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [swrm_pkg::DIV_NUM_W-1:0] quotient
);
  import swrm_pkg::*;

  logic [DIV_NUM_W-1:0] q_r, q_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_comb begin
    q_nxt    = q_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/swrm_dp.sv
// ----------------------------------------------------------------------------
// swrm_dp: datapath of the sliding window rate meter
// Holds the bin ring, window bounds, bin_ms register and the captured beat,
// and runs slot and rate divisions on the shared divider.
// ----------------------------------------------------------------------------
module swrm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [swrm_pkg::BIN_MS_W-1:0]   cfg_wr_data,
  input  logic [swrm_pkg::OP_W-1:0]       in_tuser,
  input  logic [swrm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  swrm_pkg::cmd_t                  cmd,
  output swrm_pkg::stat_t                 stat,
  output logic [swrm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import swrm_pkg::*;

  logic [OP_W-1:0]     op_r;
  logic [TS_W-1:0]     ts_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [BIN_MS_W-1:0] bin_ms_r;

  logic [TS_W-1:0]     start_r, start_nxt;
  logic [TS_W-1:0]     end_r, end_nxt;
  logic [TS_W-1:0]     slot_r;
  logic [BYTES_W-1:0]  bins_r   [NUM_BINS];
  logic [BYTES_W-1:0]  bins_nxt [NUM_BINS];

  logic [SUM_W-1:0]     sum_r;
  logic [BIN_IDX_W-1:0] ptr_r;
  logic [CNT_W-1:0]     left_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [PROD_W-1:0]    prod_r;
  logic [RATE_W-1:0]    rate_r;

  logic [BIN_MS_W-1:0]  bin_ms_eff;
  logic [TS_W-1:0]      q_sat;
  logic [TS_W-1:0]      slot_cl;
  logic [TS_W-1:0]      skip_n;
  logic [CNT_W-1:0]     skip_cl;
  logic [TS_W-1:0]      win_w;
  logic [CNT_W-1:0]     win_cnt;
  logic [BIN_IDX_W-1:0] off;

  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_q;

  // A bin_ms of zero divides as one.
  assign bin_ms_eff = (bin_ms_r == '0) ? BIN_MS_W'(1) : bin_ms_r;

  assign div_start = cmd.slot_div_start | cmd.rate_div_start;
  assign div_num   = cmd.rate_div_start ? DIV_NUM_W'(prod_r) : ts_r;
  assign div_den   = cmd.rate_div_start ? den_r : DIV_DEN_W'(bin_ms_eff);

  swrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Slot saturates so end still fits, and never moves behind the newest slot.
  always_comb begin
    q_sat   = (div_q > SLOT_MAX) ? SLOT_MAX : div_q;
    slot_cl = (q_sat < end_r - 1'b1) ? end_r - 1'b1 : q_sat;
  end

  always_comb begin
    skip_n  = slot_r + 1'b1 - end_r;
    skip_cl = (skip_n > TS_W'(NUM_BINS)) ? CNT_W'(NUM_BINS) : skip_n[CNT_W-1:0];
    win_w   = end_r - start_r;
    win_cnt = win_w[CNT_W-1:0];
  end

  always_comb begin
    off       = '0;
    start_nxt = start_r;
    end_nxt   = end_r;
    for (int i = 0; i < NUM_BINS; i++) begin
      bins_nxt[i] = bins_r[i];
    end
    if (cmd.advance) begin
      // Zero the bins of the slots skipped since the last beat.
      for (int i = 0; i < NUM_BINS; i++) begin
        off = BIN_IDX_W'(i) - end_r[BIN_IDX_W-1:0];
        if ({1'b0, off} < skip_cl) begin
          bins_nxt[i] = '0;
        end
      end
      end_nxt = slot_r + 1'b1;
    end
    if (cmd.clamp && (win_w > TS_W'(NUM_BINS))) begin
      start_nxt = end_r - TS_W'(NUM_BINS);
    end
    if (cmd.apply_add) begin
      bins_nxt[slot_r[BIN_IDX_W-1:0]] = bins_r[slot_r[BIN_IDX_W-1:0]] + bytes_r;
    end
    if (cmd.apply_clear) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_nxt[i] = '0;
      end
      start_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_ms_r <= BIN_MS_RESET;
      start_r  <= '0;
      end_r    <= TS_W'(1);
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        bin_ms_r <= cfg_wr_data;
      end
      start_r <= start_nxt;
      end_r   <= end_nxt;
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= bins_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_tuser;
      ts_r    <= in_tdata[TS_W-1:0];
      bytes_r <= in_tdata[TS_W+BYTES_W-1:TS_W];
    end
    if (cmd.take_slot) begin
      slot_r <= slot_cl;
    end
    if (cmd.sum_init) begin
      sum_r  <= '0;
      ptr_r  <= start_r[BIN_IDX_W-1:0];
      left_r <= win_cnt;
      den_r  <= DIV_DEN_W'(bin_ms_eff) * DIV_DEN_W'(win_cnt);
    end
    if (cmd.sum_step) begin
      sum_r  <= sum_r + SUM_W'(bins_r[ptr_r]);
      ptr_r  <= ptr_r + 1'b1;
      left_r <= left_r - 1'b1;
    end
    if (cmd.scale) begin
      prod_r <= sum_r * PROD_W'(MS_PER_SEC);
    end
    if (cmd.load_out) begin
      rate_r <= div_q[RATE_W-1:0];
    end
  end

  assign stat.op       = op_r;
  assign stat.div_done = div_done;
  assign stat.sum_last = (left_r == CNT_W'(1));

  assign out_tdata = OUT_DATA_W'(rate_r);

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_window_width: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_init |-> (win_w != '0 && win_w <= TS_W'(NUM_BINS)))
    else $error("window width out of range at query");

endmodule

FILE: rtl/swrm_ctrl.sv
// ----------------------------------------------------------------------------
// swrm_ctrl: controller of the sliding window rate meter
// Sequences one beat at a time through slot division, window advance,
// the operation itself and, for a query, summing, scaling and rate division.
// ----------------------------------------------------------------------------
module swrm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  swrm_pkg::stat_t stat,
  output swrm_pkg::cmd_t  cmd
);
  import swrm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.op) inside
          OP_ADD, OP_QUERY, OP_CLEAR: state_nxt = ST_SLOT_DIV;
          default:                    state_nxt = ST_IDLE;
        endcase
      end
      ST_SLOT_DIV: begin
        if (stat.div_done) state_nxt = ST_ADVANCE;
      end
      ST_ADVANCE:    state_nxt = ST_CLAMP;
      ST_CLAMP:      state_nxt = ST_APPLY;
      ST_APPLY: begin
        state_nxt = (stat.op == OP_QUERY) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (stat.sum_last) state_nxt = ST_SCALE;
      end
      ST_SCALE:      state_nxt = ST_RATE_START;
      ST_RATE_START: state_nxt = ST_RATE_WAIT;
      ST_RATE_WAIT: begin
        if (stat.div_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_DECODE: begin
        unique case (stat.op) inside
          OP_ADD, OP_QUERY, OP_CLEAR: cmd.slot_div_start = 1'b1;
          default:                    cmd.slot_div_start = 1'b0;
        endcase
      end
      ST_SLOT_DIV:   cmd.take_slot = stat.div_done;
      ST_ADVANCE:    cmd.advance   = 1'b1;
      ST_CLAMP:      cmd.clamp     = 1'b1;
      ST_APPLY: begin
        cmd.apply_add   = (stat.op == OP_ADD);
        cmd.apply_clear = (stat.op == OP_CLEAR);
        cmd.sum_init    = (stat.op == OP_QUERY);
      end
      ST_SUM:        cmd.sum_step       = 1'b1;
      ST_SCALE:      cmd.scale          = 1'b1;
      ST_RATE_START: cmd.rate_div_start = 1'b1;
      ST_RATE_WAIT:  cmd.load_out       = 1'b0;
      ST_RESULT:     cmd.load_out       = out_free;
      default:       cmd                = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an undelivered result");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DECODE))
    else $error("accepted beat not decoded");

endmodule

FILE: rtl/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter: byte-rate meter over a sliding time window
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// The block takes one beat at a time. Every beat with a used opcode runs the
// shared one-bit-per-cycle divider to turn its timestamp into a slot, then
// advances the window and applies its operation; after an add or a clear the
// next beat can be taken, and an unused opcode returns to idle after decode.
// A query then sums the window one bin per cycle (1 to 16 bins), scales the
// total and runs the divider a second time. The rate result sits in an output
// register, so a new beat is taken while it waits to be read; a later query
// holds in its last step until the register is free.
module sliding_window_rate_meter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [swrm_pkg::BIN_MS_W-1:0]   cfg_wr_data,   // bin_ms
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swrm_pkg::IN_DATA_W-1:0]  in_tdata,      // timestamp_ms, byte_count
  input  logic [swrm_pkg::OP_W-1:0]       in_tuser,      // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [swrm_pkg::OUT_DATA_W-1:0] out_tdata      // rate_bytes_per_sec
);
  import swrm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  swrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  swrm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_tdata   (out_tdata)
  );

endmodule
